[sv/ihp_pkg.sv]
// Package for the indexed max-heap: sizes, request and status codes,
// entry type and sequencer state type. No dependencies.
package ihp_pkg;

	localparam int CAPACITY = 64;
	localparam int ID_SPACE = 256;
	localparam int KEY_W    = 32;
	localparam int ID_W     = 8;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int FILL_W   = $clog2(CAPACITY + 1);
	localparam int CHILD_W  = SLOT_W + 2;
	localparam int ENTRY_W  = KEY_W + ID_W;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_POP    = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_EMPTY  = 3'd1;
	localparam logic [2:0] ST_FULL   = 3'd2;
	localparam logic [2:0] ST_ABSENT = 3'd3;
	localparam logic [2:0] ST_DUP    = 3'd4;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [ID_W-1:0]         id;
	} entry_t;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_LOOK   = 10'b0000000010,
		S_FETCH  = 10'b0000000100,
		S_TAKE   = 10'b0000001000,
		S_UP_RD  = 10'b0000010000,
		S_UP_CMP = 10'b0000100000,
		S_DN_RD  = 10'b0001000000,
		S_DN_CMP = 10'b0010000000,
		S_TOP_RD = 10'b0100000000,
		S_TOP    = 10'b1000000000
	} state_t;

endpackage

[sv/ihp_ram.sv]
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module ihp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wa,
	input  logic [WIDTH-1:0]         wd,
	input  logic [$clog2(DEPTH)-1:0] ra_a,
	input  logic [$clog2(DEPTH)-1:0] ra_b,
	output logic [WIDTH-1:0]         rd_a,
	output logic [WIDTH-1:0]         rd_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rd_a <= mem_q[ra_a];
		rd_b <= mem_q[ra_b];
	end

endmodule

[sv/indexed_max_heap_with_removal.sv]
// Indexed binary max-heap with insert, pop-maximum and remove-by-id.
// Insert sifts the new entry up from the end; pop and remove take an entry out, move the
// last entry into its slot (if it was not that entry) and sift it up, then down.
// Throughput: one request at a time, next one accepted the cycle after the result loads.
// Reset: asynchronous, clears entry count, presence bits and control; RAMs untouched.
// Depends on ihp_pkg and ihp_ram.
module indexed_max_heap_with_removal (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // req_type[1:0], prio_key[33:2], item_id[41:34]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata   // status, out_key, out_id, top_key, top_valid, entry_count
);

	localparam int SW = ihp_pkg::SLOT_W;
	localparam int FW = ihp_pkg::FILL_W;
	localparam int CW = ihp_pkg::CHILD_W;

	ihp_pkg::state_t state_q;
	logic [1:0]              type_q;
	logic [ihp_pkg::ID_W-1:0] id_q;
	logic signed [ihp_pkg::KEY_W-1:0] key_q;
	ihp_pkg::entry_t         mv_q;
	ihp_pkg::entry_t         rem_q;
	logic [SW-1:0]           p_q;
	logic [SW-1:0]           pos_q;
	logic                    down_q;
	logic [2:0]              status_q;
	logic [FW-1:0]           fill_q;
	logic [ihp_pkg::ID_SPACE-1:0] present_q;
	logic [87:0]             out_q;
	logic                    out_vld_q;

	ihp_pkg::entry_t rd_a, rd_b, slot_wd;
	logic [SW-1:0]   slot_ra_a, slot_ra_b, slot_wa, id_wd, id_rd, id_rd_b;
	logic [ihp_pkg::ID_W-1:0] id_ra, id_wa;
	logic            slot_we, id_we;
	logic [SW-1:0]   up_idx;
	logic [CW-1:0]   l_idx, r_idx, fill_x;
	logic            up_move, dn_move, dn_right;
	logic [FW-1:0]   fill_dec;
	logic            out_load;

	assign s_tready = (state_q == ihp_pkg::S_IDLE);
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;
	assign out_load = (state_q == ihp_pkg::S_TOP) && (!out_vld_q || m_tready);

	assign up_idx   = SW'((p_q - SW'(1)) >> 1);
	assign l_idx    = CW'({p_q, 1'b1});
	assign r_idx    = l_idx + CW'(1);
	assign fill_x   = CW'(fill_q);
	assign fill_dec = fill_q - FW'(1);
	assign up_move  = rd_a.key <= mv_q.key;

	always_comb begin
		dn_move  = 1'b0;
		dn_right = 1'b0;
		if (r_idx < fill_x) begin
			if (mv_q.key <= rd_a.key || mv_q.key <= rd_b.key) begin
				dn_move  = 1'b1;
				dn_right = rd_a.key <= rd_b.key;
			end
		end else if (r_idx == fill_x) begin
			dn_move = mv_q.key <= rd_a.key;
		end
	end

	always_comb begin
		slot_ra_a = '0;
		slot_ra_b = '0;
		case (state_q)
			ihp_pkg::S_FETCH: begin
				slot_ra_a = pos_q;
				slot_ra_b = SW'(fill_dec);
			end
			ihp_pkg::S_UP_RD: slot_ra_a = up_idx;
			ihp_pkg::S_DN_RD: begin
				slot_ra_a = SW'(l_idx);
				slot_ra_b = SW'(r_idx);
			end
			default: slot_ra_a = '0;
		endcase
	end

	assign id_ra = s_tdata[41:34];

	always_comb begin
		slot_we = 1'b0;
		slot_wa = p_q;
		slot_wd = mv_q;
		case (state_q)
			ihp_pkg::S_UP_RD: slot_we = (p_q == '0) && !down_q;
			ihp_pkg::S_UP_CMP: begin
				slot_we = up_move || !down_q;
				if (up_move) begin
					slot_wd = rd_a;
				end
			end
			ihp_pkg::S_DN_CMP: begin
				slot_we = 1'b1;
				if (dn_move) begin
					slot_wd = dn_right ? rd_b : rd_a;
				end
			end
			default: slot_we = 1'b0;
		endcase
		id_we = slot_we;
		id_wa = slot_wd.id;
		id_wd = p_q;
	end

	ihp_ram #(.WIDTH(ihp_pkg::ENTRY_W), .DEPTH(ihp_pkg::CAPACITY)) u_slot (
		.clk(clk), .we(slot_we), .wa(slot_wa), .wd(slot_wd),
		.ra_a(slot_ra_a), .ra_b(slot_ra_b), .rd_a(rd_a), .rd_b(rd_b)
	);

	ihp_ram #(.WIDTH(SW), .DEPTH(ihp_pkg::ID_SPACE)) u_id (
		.clk(clk), .we(id_we), .wa(id_wa), .wd(id_wd),
		.ra_a(id_ra), .ra_b(id_ra), .rd_a(id_rd), .rd_b(id_rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ihp_pkg::S_IDLE;
			fill_q    <= '0;
			present_q <= '0;
			out_vld_q <= 1'b0;
			down_q    <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ihp_pkg::S_IDLE: begin
					if (s_tvalid) begin
						type_q  <= s_tdata[1:0];
						key_q   <= s_tdata[33:2];
						id_q    <= s_tdata[41:34];
						state_q <= ihp_pkg::S_LOOK;
					end
				end
				ihp_pkg::S_LOOK: begin
					rem_q  <= '0;
					down_q <= (type_q != ihp_pkg::REQ_INSERT);
					case (type_q)
						ihp_pkg::REQ_INSERT: begin
							if (present_q[id_q]) begin
								status_q <= ihp_pkg::ST_DUP;
								state_q  <= ihp_pkg::S_TOP_RD;
							end else if (fill_q == FW'(ihp_pkg::CAPACITY)) begin
								status_q <= ihp_pkg::ST_FULL;
								state_q  <= ihp_pkg::S_TOP_RD;
							end else begin
								status_q         <= ihp_pkg::ST_OK;
								mv_q             <= '{key: key_q, id: id_q};
								p_q              <= SW'(fill_q);
								fill_q           <= fill_q + FW'(1);
								present_q[id_q]  <= 1'b1;
								state_q          <= ihp_pkg::S_UP_RD;
							end
						end
						ihp_pkg::REQ_POP: begin
							if (fill_q == '0) begin
								status_q <= ihp_pkg::ST_EMPTY;
								state_q  <= ihp_pkg::S_TOP_RD;
							end else begin
								status_q <= ihp_pkg::ST_OK;
								pos_q    <= '0;
								state_q  <= ihp_pkg::S_FETCH;
							end
						end
						ihp_pkg::REQ_REMOVE: begin
							if (present_q[id_q] && FW'(id_rd) < fill_q) begin
								status_q <= ihp_pkg::ST_OK;
								pos_q    <= id_rd;
								state_q  <= ihp_pkg::S_FETCH;
							end else begin
								status_q <= ihp_pkg::ST_ABSENT;
								state_q  <= ihp_pkg::S_TOP_RD;
							end
						end
						default: begin
							status_q <= ihp_pkg::ST_ABSENT;
							state_q  <= ihp_pkg::S_TOP_RD;
						end
					endcase
				end
				ihp_pkg::S_FETCH: state_q <= ihp_pkg::S_TAKE;
				ihp_pkg::S_TAKE: begin
					rem_q               <= rd_a;
					present_q[rd_a.id]  <= 1'b0;
					fill_q              <= fill_dec;
					mv_q                <= rd_b;
					p_q                 <= pos_q;
					state_q <= (FW'(pos_q) == fill_dec) ? ihp_pkg::S_TOP_RD
						: ihp_pkg::S_UP_RD;
				end
				ihp_pkg::S_UP_RD: begin
					if (p_q != '0) begin
						state_q <= ihp_pkg::S_UP_CMP;
					end else begin
						state_q <= down_q ? ihp_pkg::S_DN_RD : ihp_pkg::S_TOP_RD;
					end
				end
				ihp_pkg::S_UP_CMP: begin
					if (up_move) begin
						p_q     <= up_idx;
						state_q <= ihp_pkg::S_UP_RD;
					end else begin
						state_q <= down_q ? ihp_pkg::S_DN_RD : ihp_pkg::S_TOP_RD;
					end
				end
				ihp_pkg::S_DN_RD: state_q <= ihp_pkg::S_DN_CMP;
				ihp_pkg::S_DN_CMP: begin
					if (dn_move) begin
						p_q     <= dn_right ? SW'(r_idx) : SW'(l_idx);
						state_q <= ihp_pkg::S_DN_RD;
					end else begin
						state_q <= ihp_pkg::S_TOP_RD;
					end
				end
				ihp_pkg::S_TOP_RD: state_q <= ihp_pkg::S_TOP;
				ihp_pkg::S_TOP: begin
					if (out_load) begin
						out_q <= {5'd0, fill_q, fill_q != '0,
							(fill_q != '0) ? rd_a.key : 32'sd0,
							rem_q.id, rem_q.key, status_q};
						state_q   <= ihp_pkg::S_IDLE;
					end
				end
				default: state_q <= ihp_pkg::S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(ihp_pkg::CAPACITY))
		else $error("entry count above capacity");
	a_take_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ihp_pkg::S_TAKE |-> fill_q != '0)
		else $error("removal from empty heap");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while busy");
	a_top_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[75] == (m_tdata[82:76] != 7'd0))
		else $error("top valid disagrees with count");
`endif

endmodule
